### design/ems_pkg.sv
// ----------------------------------------------------------------------------
// ems_pkg: shared types and constants of the encoder move sequencer
// Command codes, motion modes, bridge patterns, register indexes and the
// structs passed between the top level and the step logic.
// ----------------------------------------------------------------------------
package ems_pkg;

	localparam int AMOUNT_BITS = 16;
	localparam int CMP_BITS    = (AMOUNT_BITS > 16) ? AMOUNT_BITS : 16;

	// command codes
	localparam logic [2:0] CMD_POLL   = 3'd0;
	localparam logic [2:0] CMD_FWD    = 3'd1;
	localparam logic [2:0] CMD_BACK   = 3'd2;
	localparam logic [2:0] CMD_LEFT   = 3'd3;
	localparam logic [2:0] CMD_RIGHT  = 3'd4;
	localparam logic [2:0] CMD_SAMPLE = 3'd5;
	localparam logic [2:0] CMD_STOP   = 3'd6;

	// motion codes as reported on the result channel
	localparam logic [2:0] MOTION_IDLE  = 3'd0;
	localparam logic [2:0] MOTION_FWD   = 3'd1;
	localparam logic [2:0] MOTION_BACK  = 3'd2;
	localparam logic [2:0] MOTION_LEFT  = 3'd3;
	localparam logic [2:0] MOTION_RIGHT = 3'd4;

	// H-bridge patterns, bit0 in1 .. bit3 in4
	localparam logic [3:0] BRIDGE_IDLE  = 4'd0;
	localparam logic [3:0] BRIDGE_FWD   = 4'd9;
	localparam logic [3:0] BRIDGE_BACK  = 4'd6;
	localparam logic [3:0] BRIDGE_LEFT  = 4'd10;
	localparam logic [3:0] BRIDGE_RIGHT = 4'd5;

	// register indexes
	localparam logic [1:0] REG_SPEED_LEFT  = 2'd0;
	localparam logic [1:0] REG_SPEED_RIGHT = 2'd1;
	localparam logic [1:0] REG_DUTY_FLOOR  = 2'd2;
	localparam logic [1:0] REG_DUTY_CEIL   = 2'd3;

	// register reset values
	localparam logic [7:0] SPEED_RST      = 8'd5;
	localparam logic [7:0] DUTY_FLOOR_RST = 8'd62;
	localparam logic [7:0] DUTY_CEIL_RST  = 8'd82;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_FWD   = 5'b00010,
		ST_BACK  = 5'b00100,
		ST_LEFT  = 5'b01000,
		ST_RIGHT = 5'b10000
	} mode_t;

	typedef struct packed {
		logic [7:0] speed_left;
		logic [7:0] speed_right;
		logic [7:0] duty_floor;
		logic [7:0] duty_ceiling;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] amount;
		logic [7:0]  enc_left;
		logic [7:0]  enc_right;
	} item_t;

	typedef struct packed {
		mode_t                       mode;
		logic [3:0][AMOUNT_BITS-1:0] pending;
		logic [1:0][15:0]            acc;
		logic [1:0][15:0]            held;
		logic                        waiting;
		logic [1:0][7:0]             duty;
	} seq_t;

	typedef struct packed {
		logic [2:0] motion;
		logic [3:0] bridge;
		logic [7:0] duty_left;
		logic [7:0] duty_right;
		logic       finished;
	} result_t;

endpackage

### design/encoder_move_sequencer.sv
// ----------------------------------------------------------------------------
// encoder_move_sequencer: differential-drive move sequencer
// Queues forward, backward and spin distances, sequences them against the
// wheel encoder counts and drives the H-bridge lines and wheel duties.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid/in_ready): cmd, amount and the two encoder
//   counts. Every request yields exactly one result on the result channel
//   (out_valid/out_ready): motion state, bridge lines, both duties and the
//   move-finished flag.
//   A request is captured into an input register and the step logic loads
//   the result register from it, raising out_valid, once the result register
//   is empty or being taken. One request per cycle is taken while results
//   drain, set by the single step of the sequencer state loop.
//   When the receiver stalls, the held result and the captured request wait;
//   in_ready drops only while both are occupied.
//   Reset clears the sequencer: idle, no pending moves, zero counts, both
//   duties at 62 and the registers at their defaults (speeds 5, floor 62,
//   ceiling 82). Registers are written through cfg_we/cfg_index/cfg_data
//   by the user only while the block is idle, which the block does not check.
// ----------------------------------------------------------------------------
module encoder_move_sequencer (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [15:0] amount,
	input  logic [7:0]  enc_left_count,
	input  logic [7:0]  enc_right_count,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  motion_state,
	output logic [3:0]  bridge_lines,
	output logic [7:0]  duty_left_out,
	output logic [7:0]  duty_right_out,
	output logic        move_finished,

	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import ems_pkg::*;

	cfg_t    cfg_q;
	seq_t    state_q;
	seq_t    state_nxt;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_q;
	result_t step_res;
	logic    out_valid_q;
	logic    step_go;

	assign step_go  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_left   <= SPEED_RST;
			cfg_q.speed_right  <= SPEED_RST;
			cfg_q.duty_floor   <= DUTY_FLOOR_RST;
			cfg_q.duty_ceiling <= DUTY_CEIL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPEED_LEFT:  cfg_q.speed_left   <= cfg_data;
				REG_SPEED_RIGHT: cfg_q.speed_right  <= cfg_data;
				REG_DUTY_FLOOR:  cfg_q.duty_floor   <= cfg_data;
				REG_DUTY_CEIL:   cfg_q.duty_ceiling <= cfg_data;
				default:         ;
			endcase
		end
	end

	// capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.cmd       <= cmd;
			item_s1.amount    <= amount;
			item_s1.enc_left  <= enc_left_count;
			item_s1.enc_right <= enc_right_count;
		end
	end

	ems_step u_step (
		.cfg  (cfg_q),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode    <= ST_IDLE;
			state_q.pending <= '0;
			state_q.acc     <= '0;
			state_q.held    <= '0;
			state_q.waiting <= 1'b0;
			state_q.duty    <= {DUTY_FLOOR_RST, DUTY_FLOOR_RST};
		end else if (step_go) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go) begin
			res_q <= step_res;
		end
	end

	assign out_valid      = out_valid_q;
	assign motion_state   = res_q.motion;
	assign bridge_lines   = res_q.bridge;
	assign duty_left_out  = res_q.duty_left;
	assign duty_right_out = res_q.duty_right;
	assign move_finished  = res_q.finished;

	// a running move always has distance left
	a_move_has_amount: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode != ST_IDLE |-> state_q.pending != '0)
		else $error("move running with no pending amount");

	// a move can only finish in a step that drove the bridge
	a_finish_while_driving: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.finished |-> res_q.bridge != BRIDGE_IDLE)
		else $error("move finished in an idle step");

	// after a finish the next move starts from cleared wheel counts
	a_next_move_clean: assert property (@(posedge clk) disable iff (!arst_n)
		step_go && step_res.finished |=> state_q.mode == ST_IDLE || state_q.acc == '0)
		else $error("next move started with stale accumulators");

	// every step loads a result
	a_step_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		step_go |=> out_valid_q)
		else $error("step taken without a result");

endmodule

### design/ems_step.sv
// ----------------------------------------------------------------------------
// ems_step: one sequencer step
// Applies a command to the sequencer state, runs the move sequencer once and
// forms the result. Purely combinational.
// ----------------------------------------------------------------------------
module ems_step (
	input  ems_pkg::cfg_t    cfg,
	input  ems_pkg::seq_t    cur,
	input  ems_pkg::item_t   item,
	output ems_pkg::seq_t    nxt,
	output ems_pkg::result_t res
);
	import ems_pkg::*;

	function automatic seq_t start_next(seq_t s);
		seq_t r;
		r = s;
		r.mode = ST_IDLE;
		if (s.pending[0] != '0) begin
			r.mode = ST_FWD;
		end else if (s.pending[1] != '0) begin
			r.mode = ST_BACK;
		end else if (s.pending[2] != '0) begin
			r.mode = ST_LEFT;
		end else if (s.pending[3] != '0) begin
			r.mode = ST_RIGHT;
		end
		if (r.mode != ST_IDLE) begin
			r.acc = '0;
		end
		return r;
	endfunction

	function automatic logic [7:0] correct_duty(logic [7:0] duty, logic [7:0] speed,
			logic [15:0] count, logic [7:0] lo, logic [7:0] hi);
		logic signed [17:0] v;
		v = signed'(18'(duty)) + signed'(18'(speed)) - signed'(18'(count));
		if (v < signed'(18'(lo))) begin
			v = signed'(18'(lo));
		end
		if (v > signed'(18'(hi))) begin
			v = signed'(18'(hi));
		end
		return v[7:0];
	endfunction

	function automatic logic [2:0] motion_code(mode_t m);
		case (m)
			ST_FWD:   motion_code = MOTION_FWD;
			ST_BACK:  motion_code = MOTION_BACK;
			ST_LEFT:  motion_code = MOTION_LEFT;
			ST_RIGHT: motion_code = MOTION_RIGHT;
			default:  motion_code = MOTION_IDLE;
		endcase
	endfunction

	seq_t                 s;
	logic [3:0]           bridge;
	logic                 fin;
	logic [1:0]           k;
	logic [16:0]          acc_sum;
	logic [15:0]          mean;

	always_comb begin
		s      = cur;
		bridge = BRIDGE_IDLE;
		fin    = 1'b0;
		k      = 2'd0;
		acc_sum = '0;
		mean    = '0;

		case (item.cmd)
			CMD_FWD:   s.pending[0] = s.pending[0] + AMOUNT_BITS'(item.amount);
			CMD_BACK:  s.pending[1] = s.pending[1] + AMOUNT_BITS'(item.amount);
			CMD_LEFT:  s.pending[2] = s.pending[2] + AMOUNT_BITS'(item.amount);
			CMD_RIGHT: s.pending[3] = s.pending[3] + AMOUNT_BITS'(item.amount);
			CMD_SAMPLE: begin
				s.held[0] = s.held[0] + {8'd0, item.enc_left};
				s.held[1] = s.held[1] + {8'd0, item.enc_right};
				s.waiting = 1'b1;
			end
			CMD_STOP:  s.mode = ST_IDLE;
			default:   ;
		endcase

		if (s.pending == '0) begin
			s.mode = ST_IDLE;
		end

		if (s.mode == ST_IDLE) begin
			s = start_next(s);
		end else begin
			case (s.mode)
				ST_FWD: begin
					bridge = BRIDGE_FWD;
					k      = 2'd0;
				end
				ST_BACK: begin
					bridge = BRIDGE_BACK;
					k      = 2'd1;
				end
				ST_LEFT: begin
					bridge = BRIDGE_LEFT;
					k      = 2'd2;
				end
				default: begin
					bridge = BRIDGE_RIGHT;
					k      = 2'd3;
				end
			endcase
			// consume a waiting sample: correct duties, fold counts into the move
			if (s.waiting) begin
				s.duty[0] = correct_duty(s.duty[0], cfg.speed_left, s.held[0],
					cfg.duty_floor, cfg.duty_ceiling);
				s.duty[1] = correct_duty(s.duty[1], cfg.speed_right, s.held[1],
					cfg.duty_floor, cfg.duty_ceiling);
				s.acc[0]  = s.acc[0] + s.held[0];
				s.acc[1]  = s.acc[1] + s.held[1];
				s.held    = '0;
				s.waiting = 1'b0;
			end
			acc_sum = {1'b0, s.acc[0]} + {1'b0, s.acc[1]};
			mean    = acc_sum[16:1];
			if (!(CMP_BITS'(s.pending[k]) > CMP_BITS'(mean))) begin
				s.pending[k] = '0;
				fin          = 1'b1;
				s            = start_next(s);
			end
		end
	end

	assign nxt            = s;
	assign res.motion     = motion_code(s.mode);
	assign res.bridge     = bridge;
	assign res.duty_left  = s.duty[0];
	assign res.duty_right = s.duty[1];
	assign res.finished   = fin;

endmodule
